>>> src/hsc_pkg.sv
// Shared types, constants and codes for the hashed sample count table.
`timescale 1ns / 1ps

package hsc_pkg;

    // Table geometry (TABLE_SIZE must be a power of two)
    localparam int TABLE_SIZE  = 16384;
    localparam int PROBE_LIMIT = 32;
    localparam int IDX_W       = $clog2(TABLE_SIZE);
    localparam int PRB_W       = $clog2(PROBE_LIMIT + 1);

    // Hash: only product bits [HASH_W-1:32] are needed for the slot index
    localparam int HASH_W = 32 + IDX_W;
    localparam int HALF_W = (HASH_W + 1) / 2;
    localparam int HI_W   = HASH_W - HALF_W;
    localparam int PROD_W = 2 * HALF_W;

    localparam logic [63:0]       HASH_MULT = 64'd11400714819323198485;
    localparam logic [HALF_W-1:0] MULT_LO   = HASH_MULT[HALF_W-1:0];
    localparam logic [HI_W-1:0]   MULT_HI   = HASH_MULT[HASH_W-1:HALF_W];

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        ST_EXISTING = 3'd0,
        ST_NEW      = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_DROPPED  = 3'd3,
        ST_READ     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_DROP   = 2'd1,
        OP_READ   = 2'd2
    } t_op;

    typedef struct packed {
        logic        func;
        logic        has_interpreter;
        logic [63:0] method_key;
        logic [13:0] read_index;
    } t_cmd;

    typedef struct packed {
        t_status     status;
        logic [13:0] slot_index;
        logic [63:0] slot_key;
        logic [31:0] slot_count;
        logic [63:0] total_samples;
        logic [63:0] overflow_samples;
        logic [63:0] dropped_samples;
    } t_result;

    typedef struct packed {
        t_op              op;
        logic [63:0]      key;
        logic [IDX_W-1:0] index;
    } t_job;

    typedef struct packed {
        logic [63:0] key;
        logic [31:0] count;
    } t_slot;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_flags;

endpackage

>>> src/hsc_front.sv
// Front end: takes commands, classifies them and hashes sample keys.
`timescale 1ns / 1ps

module hsc_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  hsc_pkg::t_cmd         i_cmd,
    input  hsc_pkg::t_queue_flags i_q_flags,
    output logic                  o_push,
    output hsc_pkg::t_job         o_job,
    output logic                  o_busy
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_PUSH = 3'b100
    } t_fstate;

    t_fstate                     r_state, n_state;
    hsc_pkg::t_job               r_job, n_job;
    logic [1:0]                  r_step, n_step;
    logic [hsc_pkg::HASH_W-1:0]  r_acc, n_acc;
    logic [hsc_pkg::PROD_W-1:0]  r_prod;
    logic [hsc_pkg::HALF_W-1:0]  op_a, op_b;

    // Shared multiplier: three partial products of the low hash bits
    always_comb begin
        case (r_step)
            2'd1: begin
                op_a = r_job.key[hsc_pkg::HALF_W-1:0];
                op_b = hsc_pkg::HALF_W'(hsc_pkg::MULT_HI);
            end
            2'd2: begin
                op_a = hsc_pkg::HALF_W'(r_job.key[hsc_pkg::HASH_W-1:hsc_pkg::HALF_W]);
                op_b = hsc_pkg::MULT_LO;
            end
            default: begin
                op_a = r_job.key[hsc_pkg::HALF_W-1:0];
                op_b = hsc_pkg::MULT_LO;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_job   = r_job;
        n_step  = r_step;
        n_acc   = r_acc;
        unique case (r_state)
            F_IDLE: begin
                if (i_accept) begin
                    n_job.key   = i_cmd.method_key;
                    n_job.index = hsc_pkg::IDX_W'(i_cmd.read_index);
                    n_step      = 2'd0;
                    if (i_cmd.func) begin
                        n_job.op = hsc_pkg::OP_READ;
                        n_state  = F_PUSH;
                    end else if (!i_cmd.has_interpreter || i_cmd.method_key == 64'd0) begin
                        n_job.op = hsc_pkg::OP_DROP;
                        n_state  = F_PUSH;
                    end else begin
                        n_job.op = hsc_pkg::OP_RECORD;
                        n_state  = F_MUL;
                    end
                end
            end
            F_MUL: begin
                n_step = r_step + 2'd1;
                if (r_step == 2'd1) begin
                    n_acc = r_prod[hsc_pkg::HASH_W-1:0];
                end else if (r_step != 2'd0) begin
                    n_acc = r_acc + {r_prod[hsc_pkg::HI_W-1:0], {hsc_pkg::HALF_W{1'b0}}};
                end
                if (r_step == 2'd3) begin
                    n_job.index = n_acc[hsc_pkg::HASH_W-1:32];
                    n_state     = F_PUSH;
                end
            end
            F_PUSH: begin
                if (!i_q_flags.full) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_job  <= n_job;
        r_step <= n_step;
        r_acc  <= n_acc;
        r_prod <= hsc_pkg::PROD_W'(op_a) * hsc_pkg::PROD_W'(op_b);
    end

    assign o_push = (r_state == F_PUSH) && !i_q_flags.full;
    assign o_job  = r_job;
    assign o_busy = (r_state != F_IDLE);

endmodule

>>> src/hsc_queue.sv
// Small in-order job queue between the front and the back end.
`timescale 1ns / 1ps

module hsc_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  hsc_pkg::t_job         i_job,
    input  logic                  i_pop,
    output hsc_pkg::t_job         o_head,
    output hsc_pkg::t_queue_flags o_flags
);

    hsc_pkg::t_job               r_entry [hsc_pkg::QUEUE_DEPTH];
    logic [hsc_pkg::QPTR_W-1:0]  r_wr_ptr, r_rd_ptr;
    logic [hsc_pkg::QCNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_job;
        end
    end

    assign o_head        = r_entry[r_rd_ptr];
    assign o_flags.full  = (r_count == hsc_pkg::QCNT_W'(hsc_pkg::QUEUE_DEPTH));
    assign o_flags.empty = (r_count == '0);

endmodule

>>> src/hsc_back.sv
// Back end: slot memory, clearing pass, linear probe, counters and results.
`timescale 1ns / 1ps

module hsc_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  hsc_pkg::t_queue_flags i_q_flags,
    input  hsc_pkg::t_job         i_head,
    output logic                  o_pop,
    output logic                  o_clearing,
    output logic                  o_done,
    output hsc_pkg::t_result      o_result
);

    typedef enum logic [2:0] {
        B_CLEAR = 3'b001,
        B_IDLE  = 3'b010,
        B_PROBE = 3'b100
    } t_bstate;

    t_bstate                    r_state, n_state;
    logic [hsc_pkg::IDX_W-1:0]  r_addr, n_addr;
    logic [hsc_pkg::PRB_W-1:0]  r_probe, n_probe;
    hsc_pkg::t_job              r_job, n_job;
    logic [63:0]                r_total, n_total;
    logic [63:0]                r_overflow, n_overflow;
    logic [63:0]                r_dropped, n_dropped;
    logic                       r_done, n_done;
    hsc_pkg::t_result           r_result, n_result;

    hsc_pkg::t_slot             r_slot_mem [hsc_pkg::TABLE_SIZE];
    hsc_pkg::t_slot             r_rd_data;
    logic                       rd_en, wr_en;
    logic [hsc_pkg::IDX_W-1:0]  wr_addr;
    hsc_pkg::t_slot             wr_data;

    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_probe    = r_probe;
        n_job      = r_job;
        n_total    = r_total;
        n_overflow = r_overflow;
        n_dropped  = r_dropped;
        n_done     = 1'b0;
        n_result   = r_result;
        o_pop      = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = r_addr;
        wr_data    = '0;
        unique case (r_state)
            B_CLEAR: begin
                wr_en  = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == '1) begin
                    n_state = B_IDLE;
                end
            end
            B_IDLE: begin
                if (!i_q_flags.empty) begin
                    o_pop   = 1'b1;
                    n_job   = i_head;
                    n_addr  = i_head.index;
                    n_probe = '0;
                    unique case (i_head.op)
                        hsc_pkg::OP_DROP: begin
                            n_dropped           = r_dropped + 64'd1;
                            n_done              = 1'b1;
                            n_result.status     = hsc_pkg::ST_DROPPED;
                            n_result.slot_index = '0;
                            n_result.slot_key   = '0;
                            n_result.slot_count = '0;
                        end
                        hsc_pkg::OP_RECORD: begin
                            n_total = r_total + 64'd1;
                            rd_en   = 1'b1;
                            n_state = B_PROBE;
                        end
                        default: begin
                            rd_en   = 1'b1;
                            n_state = B_PROBE;
                        end
                    endcase
                end
            end
            B_PROBE: begin
                n_result.slot_index = 14'(r_addr);
                if (r_job.op == hsc_pkg::OP_READ) begin
                    n_done              = 1'b1;
                    n_result.status     = hsc_pkg::ST_READ;
                    n_result.slot_key   = r_rd_data.key;
                    n_result.slot_count = r_rd_data.count;
                    n_state             = B_IDLE;
                end else if (r_rd_data.key == r_job.key) begin
                    wr_en               = 1'b1;
                    wr_data.key         = r_job.key;
                    wr_data.count       = r_rd_data.count + 32'd1;
                    n_done              = 1'b1;
                    n_result.status     = hsc_pkg::ST_EXISTING;
                    n_result.slot_key   = r_job.key;
                    n_result.slot_count = wr_data.count;
                    n_state             = B_IDLE;
                end else if (r_rd_data.key == 64'd0) begin
                    wr_en               = 1'b1;
                    wr_data.key         = r_job.key;
                    wr_data.count       = 32'd1;
                    n_done              = 1'b1;
                    n_result.status     = hsc_pkg::ST_NEW;
                    n_result.slot_key   = r_job.key;
                    n_result.slot_count = 32'd1;
                    n_state             = B_IDLE;
                end else if (r_probe == hsc_pkg::PRB_W'(hsc_pkg::PROBE_LIMIT - 1)) begin
                    n_overflow          = r_overflow + 64'd1;
                    n_done              = 1'b1;
                    n_result.status     = hsc_pkg::ST_OVERFLOW;
                    n_result.slot_index = '0;
                    n_result.slot_key   = '0;
                    n_result.slot_count = '0;
                    n_state             = B_IDLE;
                end else begin
                    // advance to the next slot, wrapping at the table end
                    n_probe = r_probe + 1'b1;
                    n_addr  = r_addr + 1'b1;
                    rd_en   = 1'b1;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
        if (n_done) begin
            n_result.total_samples    = n_total;
            n_result.overflow_samples = n_overflow;
            n_result.dropped_samples  = n_dropped;
        end
    end

    // Slot memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_slot_mem[n_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= B_CLEAR;
            r_addr     <= '0;
            r_total    <= '0;
            r_overflow <= '0;
            r_dropped  <= '0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_total    <= n_total;
            r_overflow <= n_overflow;
            r_dropped  <= n_dropped;
            r_done     <= n_done;
        end
        r_probe  <= n_probe;
        r_job    <= n_job;
        r_result <= n_result;
    end

    assign o_clearing = (r_state == B_CLEAR);
    assign o_done     = r_done;
    assign o_result   = r_result;

endmodule

>>> src/hashed_sample_count_table.sv
// Top level of the hashed sample count table: front end, job queue, back end.
`timescale 1ns / 1ps
// Flow: the front end classifies a command and hashes a sample with the four-step
//   shared hash multiplier; the back end reads one slot for a read and probes N slots
//   for a sample (N = 1 to 32); a drop needs no slot. The back end takes a new job
//   only when idle, and the front end takes a new command only after its last job
//   is pushed into the queue. The job queue holds 2 jobs.
// Reset: synchronous, active low. A clearing pass over all 16384 slots (one slot per
//   cycle) follows reset; busy stays high until it ends. No result backpressure.

module hashed_sample_count_table (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  hsc_pkg::t_cmd    i_cmd,
    output logic             o_done,
    output hsc_pkg::t_result o_result
);

    logic                  accept;
    logic                  front_busy;
    logic                  clearing;
    logic                  push;
    logic                  pop;
    hsc_pkg::t_job         push_job;
    hsc_pkg::t_job         head_job;
    hsc_pkg::t_queue_flags q_flags;

    // A transfer happens when start meets a free front end after the clearing pass
    assign busy   = front_busy || clearing;
    assign accept = start && !busy;

    // Classify and hash; hold the job until the queue has room
    hsc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_cmd     (i_cmd),
        .i_q_flags (q_flags),
        .o_push    (push),
        .o_job     (push_job),
        .o_busy    (front_busy)
    );

    // Decouple hashing from probing so each side stalls on its own
    hsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_flags (q_flags)
    );

    // Probe the slot memory one slot per cycle, update counters, drive results
    hsc_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_flags  (q_flags),
        .i_head     (head_job),
        .o_pop      (pop),
        .o_clearing (clearing),
        .o_done     (o_done),
        .o_result   (o_result)
    );

endmodule

>>> src/hsc_checker.sv
// Port-level checker for the hashed sample count table, bound to the top level.
`timescale 1ns / 1ps

module hsc_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_start,
    input logic             i_busy,
    input logic             i_done,
    input hsc_pkg::t_result i_result
);

    logic [63:0] r_drops;
    logic [63:0] r_ovfs;

    // Count dropped and overflow results seen since reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drops <= '0;
            r_ovfs  <= '0;
        end else if (i_done) begin
            if (i_result.status == hsc_pkg::ST_DROPPED) begin
                r_drops <= r_drops + 64'd1;
            end
            if (i_result.status == hsc_pkg::ST_OVERFLOW) begin
                r_ovfs <= r_ovfs + 64'd1;
            end
        end
    end

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> i_busy)
        else $error("busy low right after reset");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !i_busy) |=> i_busy)
        else $error("busy low right after a transfer");

    a_dropped_tally: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |-> (i_result.dropped_samples ==
                    r_drops + 64'(i_result.status == hsc_pkg::ST_DROPPED)))
        else $error("dropped counter disagrees with dropped results");

    a_overflow_tally: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_done |-> (i_result.overflow_samples ==
                    r_ovfs + 64'(i_result.status == hsc_pkg::ST_OVERFLOW)))
        else $error("overflow counter disagrees with overflow results");

endmodule

bind hashed_sample_count_table hsc_checker u_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_start  (start),
    .i_busy   (busy),
    .i_done   (o_done),
    .i_result (o_result)
);
